>>> hw/rtl/eos_bilinear_table_lookup_core_defines.svh
// assertion macros for the table lookup core checker
// expects clk_i and rst_ni in the scope of use
`ifndef EOS_BILINEAR_TABLE_LOOKUP_CORE_DEFINES_SVH
`define EOS_BILINEAR_TABLE_LOOKUP_CORE_DEFINES_SVH

// same-cycle implication
`define EBTL_ASSERT_IMP(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define EBTL_ASSERT_NXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> hw/rtl/ebtl_pkg.sv
// shared types, constants and fixed-point helpers of the table lookup core
// no dependencies
package ebtl_pkg;

  localparam int NB_POINTS = 64;
  localparam int E_POINTS  = 256;
  localparam int N_QTY     = 5;
  localparam int N_CFG     = 8;
  localparam int CFG_IDX_W = 3;

  localparam int NB_W  = ($clog2(NB_POINTS) < 2) ? 2 : $clog2(NB_POINTS);
  localparam int E_W   = ($clog2(E_POINTS) < 2) ? 2 : $clog2(E_POINTS);
  localparam int NBH_W = NB_W - 1;
  localparam int EH_W  = E_W - 1;

  localparam int BASE_DEPTH = 1 << NBH_W;
  localparam int GRID_AW    = 1 + NBH_W + EH_W;
  localparam int GRID_DEPTH = 1 << GRID_AW;

  typedef logic signed [33:0] q_t;

  localparam q_t Q_ONE    = 34'sd65536;
  localparam q_t Q_NB_LIM = q_t'((NB_POINTS - 1) * 65536);
  localparam q_t Q_E_LIM  = q_t'((E_POINTS - 1) * 65536);

  typedef enum logic [1:0] {
    KIND_FULL = 2'd0,
    KIND_PRES = 2'd1,
    KIND_LOAD = 2'd2,
    KIND_NONE = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    QTY_P    = 3'd0,
    QTY_T    = 3'd1,
    QTY_MUB  = 3'd2,
    QTY_MUQ  = 3'd3,
    QTY_MUS  = 3'd4,
    QTY_BASE = 3'd5
  } qty_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SMALL_NB_ORG = 3'd0,
    CFG_SMALL_NB_INV = 3'd1,
    CFG_SMALL_E_ORG  = 3'd2,
    CFG_SMALL_E_INV  = 3'd3,
    CFG_BIG_NB_ORG   = 3'd4,
    CFG_BIG_NB_INV   = 3'd5,
    CFG_BIG_E_ORG    = 3'd6,
    CFG_BIG_E_INV    = 3'd7
  } cfg_e;

  typedef struct packed {
    logic [1:0]         kind;
    logic               table_select;
    logic [2:0]         quantity;
    logic [5:0]         nb_index;
    logic [7:0]         e_index;
    logic signed [31:0] load_value;
    logic signed [31:0] energy_density;
    logic signed [31:0] baryon_density;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pressure;
    logic [30:0]        temperature;
    logic signed [31:0] mu_baryon;
    logic signed [31:0] mu_charge;
    logic signed [31:0] mu_strange;
    logic               used_big_table;
    logic               zeroed;
  } out_item_t;

  // baseline write port
  typedef struct packed {
    logic            we;
    logic [NB_W-1:0] idx;
    logic [31:0]     val;
  } bw_t;

  // grid write port
  typedef struct packed {
    logic            we;
    logic [2:0]      qty;
    logic            sel;
    logic [NB_W-1:0] nbi;
    logic [E_W-1:0]  ei;
    logic [31:0]     val;
  } gw_t;

  // located position on one grid
  typedef struct packed {
    logic [NB_W-1:0] in;
    logic [E_W-1:0]  ie;
    q_t              dn;
    q_t              de;
    logic            neg;
    logic            lt;
    logic            floor_hit;
  } loc_t;

  typedef struct packed {
    logic            g;
    logic [NB_W-1:0] in;
    logic [E_W-1:0]  ie;
    q_t              dn;
    q_t              de;
  } pos_t;

  function automatic q_t sat_q(input logic signed [69:0] x);
    q_t r;
    if (x > 70'sd8589934591) begin
      r = 34'sh1_ffff_ffff;
    end else if (x < -70'sd8589934592) begin
      r = 34'sh2_0000_0000;
    end else begin
      r = x[33:0];
    end
    return r;
  endfunction

  function automatic q_t sat_shr(input logic signed [69:0] x);
    logic signed [69:0] y;
    y = x >>> 16;
    return sat_q(y);
  endfunction

  function automatic logic signed [31:0] clamp_s32(input q_t x);
    logic signed [31:0] r;
    if (x > 34'sd2147483647) begin
      r = 32'sh7fff_ffff;
    end else if (x < -34'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  function automatic logic [30:0] clamp_u31(input q_t x);
    logic [30:0] r;
    if (x[33]) begin
      r = '0;
    end else if (x > 34'sd2147483647) begin
      r = '1;
    end else begin
      r = x[30:0];
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/ebtl_in_if.sv
// input channel of the table lookup core: valid, ready and one item
// depends on ebtl_pkg
interface ebtl_in_if;
  import ebtl_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/ebtl_out_if.sv
// result channel of the table lookup core: valid, ready and one result
// depends on ebtl_pkg
interface ebtl_out_if;
  import ebtl_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/ebtl_ram.sv
// generic single write port ram with registered read and read enable
// no dependencies
module ebtl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

>>> hw/rtl/ebtl_locate.sv
// locates a query on one grid: baryon position, baseline, energy position
// depends on ebtl_pkg and ebtl_ram, nine register stages
module ebtl_locate (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [31:0] e_i,
  input  logic signed [31:0] nb_i,
  input  logic signed [31:0] nb_org_i,
  input  logic [31:0]        nb_inv_i,
  input  logic signed [31:0] e_org_i,
  input  logic [31:0]        e_inv_i,
  input  ebtl_pkg::bw_t      bw_i,
  output ebtl_pkg::loc_t     loc_o
);
  import ebtl_pkg::*;

  typedef struct packed {
    logic [NB_W-1:0] in;
    q_t              dn;
    logic            neg;
    logic            lt;
  } nbc_t;

  q_t                 a1_q;
  logic signed [31:0] e_q [1:7];
  q_t                 fn2_q;
  nbc_t               c_q [3:9];
  nbc_t               c3_d;
  logic [31:0]        brd [2];
  logic signed [31:0] b0, b1;
  logic signed [32:0] diff;
  logic signed [66:0] prod5_d, prod5_q;
  logic signed [31:0] b0_5_q;
  q_t                 ebas6_q, ep7_d, ep7_q, fe8_q, t7;
  logic signed [66:0] pfn, pfe;
  logic [E_W-1:0]     ie9_d;
  loc_t               loc9_q;

  assign pfn = a1_q * $signed({1'b0, nb_inv_i});

  always_comb begin
    logic signed [69:0] inq;
    c3_d.neg = (fn2_q <= -Q_ONE);
    c3_d.lt  = (fn2_q < Q_NB_LIM);
    if (fn2_q[33]) begin
      c3_d.in = '0;
    end else if ({1'b0, fn2_q[32:16]} > 18'(NB_POINTS - 2)) begin
      c3_d.in = NB_W'(NB_POINTS - 2);
    end else begin
      c3_d.in = fn2_q[16 +: NB_W];
    end
    inq     = 70'($signed({1'b0, c3_d.in, 16'h0000}));
    c3_d.dn = sat_q(70'(fn2_q) - inq);
  end

  for (genvar p = 0; p < 2; p++) begin : g_base
    logic [NB_W-1:0] row;
    assign row = (c_q[3].in[0] == p[0]) ? c_q[3].in : c_q[3].in + NB_W'(1);
    ebtl_ram #(.WIDTH(32), .DEPTH(BASE_DEPTH)) u_ram (
      .clk_i   (clk_i),
      .we_i    (en_i & bw_i.we & (bw_i.idx[0] == p[0])),
      .waddr_i (bw_i.idx[NB_W-1:1]),
      .wdata_i (bw_i.val),
      .re_i    (en_i),
      .raddr_i (row[NB_W-1:1]),
      .rdata_o (brd[p])
    );
  end

  assign b0      = c_q[4].in[0] ? brd[1] : brd[0];
  assign b1      = c_q[4].in[0] ? brd[0] : brd[1];
  assign diff    = 33'(b1) - 33'(b0);
  assign prod5_d = c_q[4].dn * diff;

  assign t7    = sat_q(70'(e_q[6]) - 70'(ebas6_q));
  assign ep7_d = sat_q(70'(t7) - 70'(e_org_i));
  assign pfe   = ep7_q * $signed({1'b0, e_inv_i});

  always_comb begin
    if (fe8_q[33]) begin
      ie9_d = '0;
    end else if (fe8_q[32:16] > 17'(E_POINTS - 2)) begin
      ie9_d = E_W'(E_POINTS - 2);
    end else begin
      ie9_d = fe8_q[16 +: E_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a1_q    <= 34'(nb_i) - 34'(nb_org_i);
      e_q[1]  <= e_i;
      for (int k = 2; k <= 7; k++) begin
        e_q[k] <= e_q[k-1];
      end
      fn2_q   <= sat_shr(70'(pfn));
      c_q[3]  <= c3_d;
      for (int k = 4; k <= 9; k++) begin
        c_q[k] <= c_q[k-1];
      end
      prod5_q <= prod5_d;
      b0_5_q  <= b0;
      ebas6_q <= sat_q(70'(b0_5_q) + 70'(sat_shr(70'(prod5_q))));
      ep7_q   <= ep7_d;
      fe8_q   <= sat_shr(70'(pfe));
      loc9_q.in        <= c_q[8].in;
      loc9_q.dn        <= c_q[8].dn;
      loc9_q.ie        <= ie9_d;
      loc9_q.de        <= sat_q(70'(fe8_q) - 70'($signed({1'b0, ie9_d, 16'h0000})));
      loc9_q.neg       <= c_q[8].neg | (fe8_q <= -Q_ONE);
      loc9_q.lt        <= c_q[8].lt & (fe8_q < Q_E_LIM);
      loc9_q.floor_hit <= (fe8_q < Q_ONE);
    end
  end

  assign loc_o = loc9_q;
endmodule

>>> hw/rtl/ebtl_interp.sv
// bilinear weights, grid memories in four parity banks and the weighted sums
// depends on ebtl_pkg and ebtl_ram, five register stages
module ebtl_interp (
  input  logic           clk_i,
  input  logic           en_i,
  input  ebtl_pkg::pos_t pos_i,
  input  ebtl_pkg::gw_t  gw_i,
  output ebtl_pkg::q_t   acc_o [ebtl_pkg::N_QTY]
);
  import ebtl_pkg::*;

  q_t                 wn [2];
  q_t                 we [2];
  logic signed [67:0] wp11_q [4];
  logic               g11_q;
  logic [NB_W-1:0]    in11_q;
  logic [E_W-1:0]     ie11_q;
  q_t                 wt12_q [4];
  logic               pn12_q, pe12_q;
  logic [31:0]        rd [N_QTY][4];
  logic signed [65:0] p13_q [N_QTY][4];
  q_t                 s14_q [N_QTY];
  q_t                 t2_14_q [N_QTY];
  q_t                 t3_14_q [N_QTY];
  q_t                 acc15_q [N_QTY];

  assign wn[0] = sat_q(70'(Q_ONE) - 70'(pos_i.dn));
  assign wn[1] = pos_i.dn;
  assign we[0] = sat_q(70'(Q_ONE) - 70'(pos_i.de));
  assign we[1] = pos_i.de;

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [NB_W-1:0]    row;
    logic [E_W-1:0]     col;
    logic [GRID_AW-1:0] raddr, waddr;
    logic               bank_hit;
    assign row = (in11_q[0] == b[1]) ? in11_q : in11_q + NB_W'(1);
    assign col = (ie11_q[0] == b[0]) ? ie11_q : ie11_q + E_W'(1);
    assign raddr = {g11_q, row[NB_W-1:1], col[E_W-1:1]};
    assign waddr = {gw_i.sel, gw_i.nbi[NB_W-1:1], gw_i.ei[E_W-1:1]};
    assign bank_hit = en_i & gw_i.we & (gw_i.nbi[0] == b[1]) & (gw_i.ei[0] == b[0]);
    for (genvar q = 0; q < N_QTY; q++) begin : g_qty
      ebtl_ram #(.WIDTH(32), .DEPTH(GRID_DEPTH)) u_ram (
        .clk_i   (clk_i),
        .we_i    (bank_hit & (gw_i.qty == 3'(q))),
        .waddr_i (waddr),
        .wdata_i (gw_i.val),
        .re_i    (en_i),
        .raddr_i (raddr),
        .rdata_o (rd[q][b])
      );
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int c = 0; c < 4; c++) begin
        wp11_q[c] <= wn[c/2] * we[c%2];
        wt12_q[c] <= sat_shr(70'(wp11_q[c]));
      end
      g11_q  <= pos_i.g;
      in11_q <= pos_i.in;
      ie11_q <= pos_i.ie;
      pn12_q <= in11_q[0];
      pe12_q <= ie11_q[0];
      for (int q = 0; q < N_QTY; q++) begin
        for (int c = 0; c < 4; c++) begin
          p13_q[q][c] <= wt12_q[c] *
              $signed(rd[q][{pn12_q ^ c[1], pe12_q ^ c[0]}]);
        end
        s14_q[q]   <= sat_q(70'(sat_shr(70'(p13_q[q][0]))) +
                            70'(sat_shr(70'(p13_q[q][1]))));
        t2_14_q[q] <= sat_shr(70'(p13_q[q][2]));
        t3_14_q[q] <= sat_shr(70'(p13_q[q][3]));
        acc15_q[q] <= sat_q(70'(sat_q(70'(s14_q[q]) + 70'(t2_14_q[q]))) +
                            70'(t3_14_q[q]));
      end
    end
  end

  assign acc_o = acc15_q;
endmodule

>>> hw/rtl/eos_bilinear_table_lookup_core.sv
// channel   dir  handshake      payload
// in_i      in   valid/ready    in_item_t: query or load item
// out_o     out  valid/ready    out_item_t: one result per query
// cfg       in   cfg_we_i       cfg_idx_i, cfg_data_i
//
// one item per cycle while the output stage is not full
// the pipeline stages cover the baseline read, the two multiplies per axis and the
// grid memory read with its weighted sum
// loads produce no result; memories are not cleared after reset
// a two-entry output stage (register plus skid) lets input continue while
// one result waits; the pipeline halts only when both are full
module eos_bilinear_table_lookup_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  ebtl_in_if.sink                        in_i,
  ebtl_out_if.source                     out_o,
  input  logic                           cfg_we_i,
  input  logic [ebtl_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]                    cfg_data_i
);
  import ebtl_pkg::*;

  localparam int LAST = 15;

  typedef struct packed {
    kind_e           kind;
    logic            ld_ok;
    logic            sel;
    logic [2:0]      qty;
    logic [NB_W-1:0] nbi;
    logic [E_W-1:0]  ei;
    logic [31:0]     val;
    logic            g;
    logic            neg;
    logic            floor_hit;
  } ctl_t;

  logic [31:0] cfg_q [N_CFG];
  logic        en, acc_in;
  logic        v_q [1:LAST];
  ctl_t        ctl_q [1:LAST];
  ctl_t        ctl1_d, ctl10_d;
  loc_t        loc_s, loc_b;
  pos_t        pos10_q, pos10_d;
  bw_t         bw_s, bw_b;
  gw_t         gw;
  q_t          acc [N_QTY];
  out_item_t   res_d, out_q, skid_q;
  logic        res_v, out_v_q, skid_v_q;
  logic        g_d;

  assign en         = ~skid_v_q;
  assign in_i.ready = en;
  assign acc_in     = in_i.valid & en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q[CFG_SMALL_NB_ORG] <= '0;
      cfg_q[CFG_SMALL_NB_INV] <= 32'd65536;
      cfg_q[CFG_SMALL_E_ORG]  <= '0;
      cfg_q[CFG_SMALL_E_INV]  <= 32'd65536;
      cfg_q[CFG_BIG_NB_ORG]   <= '0;
      cfg_q[CFG_BIG_NB_INV]   <= 32'd65536;
      cfg_q[CFG_BIG_E_ORG]    <= '0;
      cfg_q[CFG_BIG_E_INV]    <= 32'd65536;
    end else if (cfg_we_i) begin
      cfg_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  always_comb begin
    ctl1_d           = '0;
    ctl1_d.kind      = kind_e'(in_i.data.kind);
    ctl1_d.sel       = in_i.data.table_select;
    ctl1_d.qty       = in_i.data.quantity;
    ctl1_d.nbi       = NB_W'(in_i.data.nb_index);
    ctl1_d.ei        = E_W'(in_i.data.e_index);
    ctl1_d.val       = in_i.data.load_value;
    ctl1_d.ld_ok     = (in_i.data.kind == KIND_LOAD) &&
                       (in_i.data.quantity <= QTY_BASE) &&
                       (32'(in_i.data.nb_index) < NB_POINTS) &&
                       ((in_i.data.quantity == QTY_BASE) ||
                        (32'(in_i.data.e_index) < E_POINTS));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 1; k <= LAST; k++) begin
        v_q[k] <= 1'b0;
      end
    end else if (en) begin
      v_q[1] <= acc_in & (in_i.data.kind != KIND_NONE);
      for (int k = 2; k <= LAST; k++) begin
        v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ctl_q[1] <= ctl1_d;
      for (int k = 2; k <= LAST; k++) begin
        ctl_q[k] <= (k == 10) ? ctl10_d : ctl_q[k-1];
      end
      pos10_q <= pos10_d;
    end
  end

  always_comb begin
    bw_s     = '0;
    bw_s.we  = v_q[3] & ctl_q[3].ld_ok & (ctl_q[3].qty == QTY_BASE) & ~ctl_q[3].sel;
    bw_s.idx = ctl_q[3].nbi;
    bw_s.val = ctl_q[3].val;
    bw_b     = bw_s;
    bw_b.we  = v_q[3] & ctl_q[3].ld_ok & (ctl_q[3].qty == QTY_BASE) & ctl_q[3].sel;
  end

  ebtl_locate u_loc_small (
    .clk_i    (clk_i),
    .en_i     (en),
    .e_i      (in_i.data.energy_density),
    .nb_i     (in_i.data.baryon_density),
    .nb_org_i (cfg_q[CFG_SMALL_NB_ORG]),
    .nb_inv_i (cfg_q[CFG_SMALL_NB_INV]),
    .e_org_i  (cfg_q[CFG_SMALL_E_ORG]),
    .e_inv_i  (cfg_q[CFG_SMALL_E_INV]),
    .bw_i     (bw_s),
    .loc_o    (loc_s)
  );

  ebtl_locate u_loc_big (
    .clk_i    (clk_i),
    .en_i     (en),
    .e_i      (in_i.data.energy_density),
    .nb_i     (in_i.data.baryon_density),
    .nb_org_i (cfg_q[CFG_BIG_NB_ORG]),
    .nb_inv_i (cfg_q[CFG_BIG_NB_INV]),
    .e_org_i  (cfg_q[CFG_BIG_E_ORG]),
    .e_inv_i  (cfg_q[CFG_BIG_E_INV]),
    .bw_i     (bw_b),
    .loc_o    (loc_b)
  );

  // small grid serves while both positions lie below its upper limits
  assign g_d = ~loc_s.lt;

  always_comb begin
    ctl10_d           = ctl_q[9];
    ctl10_d.g         = g_d;
    ctl10_d.neg       = g_d ? loc_b.neg : loc_s.neg;
    ctl10_d.floor_hit = loc_s.floor_hit;
    pos10_d.g         = g_d;
    pos10_d.in        = g_d ? loc_b.in : loc_s.in;
    pos10_d.ie        = g_d ? loc_b.ie : loc_s.ie;
    pos10_d.dn        = g_d ? loc_b.dn : loc_s.dn;
    pos10_d.de        = g_d ? loc_b.de : loc_s.de;
  end

  always_comb begin
    gw     = '0;
    gw.we  = v_q[11] & ctl_q[11].ld_ok & (ctl_q[11].qty < QTY_BASE);
    gw.qty = ctl_q[11].qty;
    gw.sel = ctl_q[11].sel;
    gw.nbi = ctl_q[11].nbi;
    gw.ei  = ctl_q[11].ei;
    gw.val = ctl_q[11].val;
  end

  ebtl_interp u_interp (
    .clk_i (clk_i),
    .en_i  (en),
    .pos_i (pos10_q),
    .gw_i  (gw),
    .acc_o (acc)
  );

  always_comb begin
    res_d = '0;
    res_v = v_q[LAST] &
            ((ctl_q[LAST].kind == KIND_FULL) || (ctl_q[LAST].kind == KIND_PRES));
    if (ctl_q[LAST].kind == KIND_PRES) begin
      res_d.pressure       = {1'b0, clamp_u31(acc[QTY_P])};
      res_d.used_big_table = ctl_q[LAST].g;
    end else if (ctl_q[LAST].floor_hit) begin
      res_d.zeroed = 1'b1;
    end else if (ctl_q[LAST].neg) begin
      res_d.zeroed         = 1'b1;
      res_d.used_big_table = ctl_q[LAST].g;
    end else begin
      res_d.pressure       = clamp_s32(acc[QTY_P]);
      res_d.temperature    = clamp_u31(acc[QTY_T]);
      res_d.mu_baryon      = clamp_s32(acc[QTY_MUB]);
      res_d.mu_charge      = clamp_s32(acc[QTY_MUQ]);
      res_d.mu_strange     = clamp_s32(acc[QTY_MUS]);
      res_d.used_big_table = ctl_q[LAST].g;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || out_o.ready) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= en & res_v;
      end
    end else if (en && res_v) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || out_o.ready) begin
      if (skid_v_q) begin
        out_q <= skid_q;
      end else if (en && res_v) begin
        out_q <= res_d;
      end
    end else if (en && res_v) begin
      skid_q <= res_d;
    end
  end

  assign out_o.valid = out_v_q;
  assign out_o.data  = out_q;
endmodule

>>> hw/rtl/ebtl_checker.sv
// port-level checks on the table lookup core, bound to the top level
// depends on ebtl_pkg and the assertion macro header
`include "eos_bilinear_table_lookup_core_defines.svh"

module ebtl_checker (
  input logic                rst_ni,
  input logic                clk_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input ebtl_pkg::out_item_t out_data_i
);
  import ebtl_pkg::*;

  `EBTL_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i, "result dropped while stalled")
  `EBTL_ASSERT_NXT(a_out_stable, out_valid_i && !out_ready_i, $stable(out_data_i), "result changed while stalled")
  `EBTL_ASSERT_IMP(a_zero_vals, out_valid_i && out_data_i.zeroed, out_data_i.pressure == 0 && out_data_i.temperature == 0 && out_data_i.mu_baryon == 0 && out_data_i.mu_charge == 0 && out_data_i.mu_strange == 0, "zeroed result carries values")
  `EBTL_ASSERT_IMP(a_ready_cause, !in_ready_i, $past(out_valid_i && !out_ready_i), "input blocked without output stall")
endmodule

bind eos_bilinear_table_lookup_core ebtl_checker u_ebtl_checker (
  .rst_ni      (rst_ni),
  .clk_i       (clk_i),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
